// ----- rtl/core/jsfe_pkg.sv -----
// ============================================================================
// jsfe_pkg: shared types and constants for the JSONL string field extractor
// Character codes, result kinds, key pattern and the command word that
// travels from the parser front to the result back end.
// ============================================================================
package jsfe_pkg;

    // width of the line index on the result port
    localparam int LINE_INDEX_WIDTH = 32;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // key pattern  "s": "  is six bytes long
    localparam logic [2:0] KEY_LEN = 3'd6;

    // character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_N      = 8'd110;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_WARN = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // one accepted byte that yields results: first result plus optional
    // trailing newline (always a kind-0 byte 10 on the same line)
    typedef struct packed {
        logic                        two;
        logic [7:0]                  data;
        logic [1:0]                  kind;
        logic [LINE_INDEX_WIDTH-1:0] line;
    } t_cmd;

    // key byte at a given match position
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_QUOTE;
            3'd1:    c = 8'd115;
            3'd2:    c = CH_QUOTE;
            3'd3:    c = 8'd58;
            3'd4:    c = 8'd32;
            3'd5:    c = CH_QUOTE;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/jsfe_front.sv -----
// ============================================================================
// jsfe_front: byte parser
// Tracks key matching, string, escape, skip and halt phases per line and
// turns each accepted byte into at most one command word.
// ============================================================================
module jsfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_cmd_valid,
    output jsfe_pkg::t_cmd o_cmd
);
    import jsfe_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_STRING,
        PH_ESCAPE,
        PH_SKIP,
        PH_HALT
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [2:0]                  r_match, n_match;
    logic [LINE_INDEX_WIDTH-1:0] r_line, n_line;
    logic                        n_valid;
    t_cmd                        n_cmd;

    // next-state and command decode
    always_comb begin
        n_phase      = r_phase;
        n_match      = r_match;
        n_line       = r_line;
        n_valid      = 1'b0;
        n_cmd.two    = 1'b0;
        n_cmd.data   = 8'd0;
        n_cmd.kind   = KIND_BYTE;
        n_cmd.line   = r_line;
        case (r_phase)
            PH_SEARCH: begin
                if (i_byte == CH_NL) begin
                    n_valid    = 1'b1;
                    n_cmd.kind = KIND_ERR;
                    n_phase    = PH_HALT;
                end else begin
                    if (i_byte == key_char(r_match)) begin
                        n_match = r_match + 3'd1;
                    end else begin
                        n_match = (i_byte == CH_QUOTE) ? 3'd1 : 3'd0;
                    end
                    if (n_match == KEY_LEN) begin
                        n_phase = PH_STRING;
                        n_match = 3'd0;
                    end
                end
            end
            PH_STRING: begin
                if (i_byte == CH_QUOTE) begin
                    n_valid    = 1'b1;
                    n_cmd.data = CH_NL;
                    n_phase    = PH_SKIP;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else if (i_byte == CH_NL) begin
                    // raw newline plus terminating newline
                    n_valid    = 1'b1;
                    n_cmd.two  = 1'b1;
                    n_cmd.data = CH_NL;
                    n_phase    = PH_SEARCH;
                    n_match    = 3'd0;
                    n_line     = r_line + 1'b1;
                end else begin
                    n_valid    = 1'b1;
                    n_cmd.data = i_byte;
                end
            end
            PH_ESCAPE: begin
                n_phase = PH_STRING;
                n_valid = 1'b1;
                if (i_byte == CH_BSLASH || i_byte == CH_QUOTE) begin
                    n_cmd.data = i_byte;
                end else if (i_byte == CH_N) begin
                    n_cmd.data = CH_NL;
                end else if (i_byte == CH_NL) begin
                    // warning for the dangling backslash, then line end
                    n_cmd.two  = 1'b1;
                    n_cmd.kind = KIND_WARN;
                    n_cmd.data = CH_NL;
                    n_phase    = PH_SEARCH;
                    n_match    = 3'd0;
                    n_line     = r_line + 1'b1;
                end else begin
                    n_cmd.kind = KIND_WARN;
                    n_cmd.data = i_byte;
                end
            end
            PH_SKIP: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_SEARCH;
                    n_match = 3'd0;
                    n_line  = r_line + 1'b1;
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // state and registered command output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_match     <= 3'd0;
            r_line      <= '0;
            o_cmd_valid <= 1'b0;
        end else begin
            o_cmd_valid <= i_accept && n_valid;
            if (i_accept) begin
                r_phase <= n_phase;
                r_match <= n_match;
                r_line  <= n_line;
            end
        end
        if (i_accept) begin
            o_cmd <= n_cmd;
        end
    end

    // matcher never rests at full key length
    a_match_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match < KEY_LEN)
        else $error("key match progress out of range");

    // halt lasts until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("left halt without reset");

endmodule

// ----- rtl/core/jsfe_fifo.sv -----
// ============================================================================
// jsfe_fifo: command queue
// Small queue that decouples the parser front from the result back end.
// ============================================================================
module jsfe_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  jsfe_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output jsfe_pkg::t_cmd o_rdata,
    output logic           o_empty
);
    import jsfe_pkg::*;

    t_cmd          r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wptr, r_rptr;
    logic [CMD_AW:0]   r_count;
    logic              wr_ok, rd_ok;

    assign o_full  = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) r_wptr <= r_wptr + 1'b1;
            if (rd_ok) r_rptr <= r_rptr + 1'b1;
            case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // a write must never find the queue full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("command queue overflow");

endmodule

// ----- rtl/core/jsfe_back.sv -----
// ============================================================================
// jsfe_back: result sequencer
// Pops command words into an output register, one result per cycle while pop
// is held; a two-result command adds the trailing newline next.
// ============================================================================
module jsfe_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_empty,
    input  jsfe_pkg::t_cmd                        i_cmd,
    output logic                                  o_cmd_rd,
    input  logic                                  i_pop,
    output logic                                  o_empty,
    output logic [7:0]                            o_out_byte,
    output logic [1:0]                            o_kind,
    output logic [jsfe_pkg::LINE_INDEX_WIDTH-1:0] o_line_index,
    output logic                                  o_is_last
);
    import jsfe_pkg::*;

    logic r_valid;
    logic r_pend;
    logic load_ok;

    // output slot may be refilled when empty or being taken
    assign load_ok  = !r_valid || i_pop;
    assign o_cmd_rd = load_ok && !r_pend && !i_cmd_empty;
    assign o_empty  = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load_ok) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_cmd_empty;
                r_pend  <= !i_cmd_empty && i_cmd.two;
            end
        end
        // payload
        if (load_ok) begin
            if (r_pend) begin
                o_out_byte <= CH_NL;
                o_kind     <= KIND_BYTE;
                o_is_last  <= 1'b1;
            end else if (!i_cmd_empty) begin
                o_out_byte   <= i_cmd.data;
                o_kind       <= i_cmd.kind;
                o_line_index <= i_cmd.line;
                o_is_last    <= !i_cmd.two;
            end
        end
    end

    // a pending newline exists exactly while a non-last word is shown
    a_pend_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == (r_valid && !o_is_last))
        else $error("pending newline out of step with output word");

    // the trailing newline follows its first word on the same line
    a_second_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && i_pop |=> r_valid && o_is_last && $stable(o_line_index))
        else $error("trailing newline lost or on wrong line");

endmodule

// ----- rtl/core/jsonl_string_field_extractor.sv -----
// ============================================================================
// jsonl_string_field_extractor: string value extractor for JSON lines
// Finds the "s": " key in each line, emits the unescaped string value
// with a newline, warns on bad escapes and halts on a line without key.
// ============================================================================
//
//  channel  | handshake        | words
//  ---------+------------------+-----------------------------------------
//  input    | push / full      | i_in_byte
//  results  | empty / pop      | o_out_byte, o_kind, o_line_index, o_is_last
//
//  One input byte per cycle while full is low; a byte giving two results
//  gives two output words. The parser registers its command on accept; it then
//  passes the queue and the output register. A four-word command queue lets the
//  parser run while the output stalls; full rises when it fills or when one
//  slot is left and a word is in flight. Synchronous active-low reset clears
//  phase, line count and all queues.
module jsonl_string_field_extractor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            i_in_byte,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [7:0]                            o_out_byte,
    output logic [1:0]                            o_kind,
    output logic [jsfe_pkg::LINE_INDEX_WIDTH-1:0] o_line_index,
    output logic                                  o_is_last
);
    import jsfe_pkg::*;

    logic q_full, q_empty, q_rd, cmd_valid, accept;
    logic q_count_hi;
    t_cmd cmd_w, cmd_r;

    // reserve a queue slot for the word in flight from the front
    assign full   = q_full || (cmd_valid && q_count_hi);
    assign accept = push && !full;

    jsfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_w)
    );

    jsfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd_w),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (cmd_r),
        .o_empty (q_empty)
    );

    // track whether the queue is one short of full
    logic [CMD_AW:0] r_level;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            case ({cmd_valid && !q_full, q_rd && !q_empty})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end
    assign q_count_hi = (r_level == (CMD_AW+1)'(CMD_DEPTH - 1));

    jsfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (q_empty),
        .i_cmd        (cmd_r),
        .o_cmd_rd     (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_line_index (o_line_index),
        .o_is_last    (o_is_last)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the JSON lines string field extractor
// Feeds text bytes through the push/full side, pops result words through
// the empty/pop side and compares each word with a cycle-free model of the
// key matcher, unescaper and line counter. A short scripted line set opens
// the run, random keyed lines follow, and a keyless line closes it with the
// error word and the halt.
// ============================================================================
module tb_top;
    import jsfe_pkg::*;

    localparam int LW           = LINE_INDEX_WIDTH;
    localparam int RANDOM_ITEMS = 1600;
    localparam int ROWS         = 29;
    localparam int OPEN_ROWS    = 23;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // characters of the key and of the script
    localparam logic [7:0] CH_S     = 8'd115;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_X     = 8'd120;
    localparam logic [7:0] CH_A     = 8'd97;
    localparam logic [7:0] KEY_BYTES [6] = '{CH_QUOTE, CH_S, CH_QUOTE, CH_COLON,
                                             CH_SPACE, CH_QUOTE};

    typedef enum logic [2:0] {
        SCAN_KEY,
        IN_STRING,
        AFTER_BSLASH,
        SKIP_LINE,
        STOPPED
    } t_scan_state;

    // one result word
    typedef struct packed {
        logic [7:0]    data;
        logic [1:0]    kind;
        logic [LW-1:0] line;
        logic          last;
    } t_word;

    // one scripted input byte, with a hand-typed word where it is obvious
    typedef struct packed {
        logic [7:0] din;
        logic       typed;
        t_word      want;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push = 1'b0;
    logic          pop = 1'b0;
    logic [7:0]    i_in_byte = 8'd0;
    logic          full;
    logic          empty;
    logic [7:0]    o_out_byte;
    logic [1:0]    o_kind;
    logic [LW-1:0] o_line_index;
    logic          o_is_last;

    // extractor model state
    t_scan_state   scan_state = SCAN_KEY;
    logic [2:0]    key_hits = 3'd0;
    logic [LW-1:0] line_no = '0;

    t_word         expected_words [$];
    int            mismatch_count = 0;
    int            bytes_fed = 0;
    int            words_checked = 0;
    int            warn_count = 0;
    int            pair_count = 0;
    int            cycle_count = 0;
    logic          send_calm = 1'b0;
    logic          take_calm = 1'b0;

    // line 0: fallback on a doubled quote, extreme bytes, escapes, close, skip
    // line 1: line end right after a backslash
    // closing: keyless line (error, halt), then bytes that must be ignored
    t_row script [ROWS] = '{
        '{CH_QUOTE,  1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_S,      1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_COLON,  1'b0, '0},
        '{CH_SPACE,  1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{8'h00,     1'b1, '{8'h00, KIND_BYTE, '0, 1'b1}},
        '{8'hFF,     1'b1, '{8'hFF, KIND_BYTE, '0, 1'b1}},
        '{CH_BSLASH, 1'b0, '0},
        '{CH_N,      1'b0, '0},
        '{CH_BSLASH, 1'b0, '0},
        '{CH_X,      1'b1, '{CH_X, KIND_WARN, '0, 1'b1}},
        '{CH_QUOTE,  1'b1, '{CH_NL, KIND_BYTE, '0, 1'b1}},
        '{CH_NL,     1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_S,      1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_COLON,  1'b0, '0},
        '{CH_SPACE,  1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_BSLASH, 1'b0, '0},
        '{CH_NL,     1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_S,      1'b0, '0},
        '{CH_NL,     1'b0, '0},
        '{CH_QUOTE,  1'b0, '0},
        '{CH_A,      1'b0, '0},
        '{CH_NL,     1'b0, '0}
    };

    jsonl_string_field_extractor DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_line_index (o_line_index),
        .o_is_last    (o_is_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
        $display("status: fail");
        $finish;
    end

    function automatic void start_next_line();
        line_no    = line_no + 1'b1;
        scan_state = SCAN_KEY;
        key_hits   = 3'd0;
    endfunction

    // advance the extractor by one byte; returns the number of words
    function automatic int extract_step(input logic [7:0] b, output t_word w0,
                                        output t_word w1);
        int n;
        n  = 0;
        w0 = '0;
        w1 = '0;
        case (scan_state)
            SCAN_KEY: begin
                if (b == CH_NL) begin
                    w0 = '{8'd0, KIND_ERR, line_no, 1'b1};
                    n = 1;
                    scan_state = STOPPED;
                end else begin
                    // substring-search fallback: a quote restarts the match
                    if (b == KEY_BYTES[key_hits])
                        key_hits = key_hits + 3'd1;
                    else
                        key_hits = (b == CH_QUOTE) ? 3'd1 : 3'd0;
                    if (key_hits == KEY_LEN) begin
                        scan_state = IN_STRING;
                        key_hits = 3'd0;
                    end
                end
            end
            IN_STRING: begin
                if (b == CH_QUOTE) begin
                    w0 = '{CH_NL, KIND_BYTE, line_no, 1'b1};
                    n = 1;
                    scan_state = SKIP_LINE;
                end else if (b == CH_BSLASH) begin
                    scan_state = AFTER_BSLASH;
                end else if (b == CH_NL) begin
                    // raw line end, then the terminating newline
                    w0 = '{CH_NL, KIND_BYTE, line_no, 1'b0};
                    w1 = '{CH_NL, KIND_BYTE, line_no, 1'b1};
                    n = 2;
                    start_next_line();
                end else begin
                    w0 = '{b, KIND_BYTE, line_no, 1'b1};
                    n = 1;
                end
            end
            AFTER_BSLASH: begin
                scan_state = IN_STRING;
                n = 1;
                if (b == CH_BSLASH || b == CH_QUOTE) begin
                    w0 = '{b, KIND_BYTE, line_no, 1'b1};
                end else if (b == CH_N) begin
                    w0 = '{CH_NL, KIND_BYTE, line_no, 1'b1};
                end else if (b == CH_NL) begin
                    // warning for the broken escape, then the newline
                    w0 = '{CH_NL, KIND_WARN, line_no, 1'b0};
                    w1 = '{CH_NL, KIND_BYTE, line_no, 1'b1};
                    n = 2;
                    start_next_line();
                end else begin
                    w0 = '{b, KIND_WARN, line_no, 1'b1};
                end
            end
            SKIP_LINE: begin
                if (b == CH_NL)
                    start_next_line();
            end
            default: scan_state = STOPPED;
        endcase
        return n;
    endfunction

    // push one byte through the input handshake, then log its expected words
    task automatic feed_byte(input logic [7:0] b, input logic typed, input t_word typed_word);
        int    gap;
        int    n;
        logic  taken;
        t_word w0;
        t_word w1;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 79) == 0)
            send_calm = !send_calm;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);

        n = extract_step(b, w0, w1);
        bytes_fed++;
        if (typed) begin
            expected_words.push_back(typed_word);
        end else begin
            if (n > 0)
                expected_words.push_back(w0);
            if (n > 1) begin
                expected_words.push_back(w1);
                pair_count++;
            end
        end
        if (n > 0 && w0.kind == KIND_WARN)
            warn_count++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
        return b;
    endfunction

    // one keyed line: noise prefix, key, value with escapes, some ending
    task automatic send_random_line();
        int         prefix_len;
        int         body_len;
        int         tail_len;
        int         pick;
        logic [7:0] b;
        prefix_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < prefix_len; i++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                b = text_byte();
            else if (pick == 1)
                b = CH_QUOTE;
            else
                b = KEY_BYTES[3'($urandom_range(0, 5))];
            feed_byte(b, 1'b0, '0);
        end
        for (int i = 0; i < 6; i++)
            feed_byte(KEY_BYTES[i], 1'b0, '0);

        body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int i = 0; i < body_len; i++) begin
            pick = $urandom_range(0, 15);
            if (pick < 10)
                b = text_byte();
            else if (pick < 12)
                b = CH_BSLASH;
            else if (pick == 12)
                b = CH_N;
            else if (pick == 13)
                b = CH_QUOTE;
            else
                b = 8'($urandom_range(32, 126));
            feed_byte(b, 1'b0, '0);
        end

        // line end inside the string, after a backslash, or after the close
        pick = $urandom_range(0, 3);
        if (pick == 1) begin
            feed_byte(CH_BSLASH, 1'b0, '0);
        end else if (pick >= 2) begin
            feed_byte(CH_QUOTE, 1'b0, '0);
            tail_len = $urandom_range(0, 5);
            for (int i = 0; i < tail_len; i++)
                feed_byte(text_byte(), 1'b0, '0);
        end
        feed_byte(CH_NL, 1'b0, '0);
    endtask

    function automatic void compare_field(input string field, input logic [LW-1:0] want,
                                          input logic [LW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls on pop, every word checked in order
    initial begin : result_side
        int    stall;
        logic  seen;
        t_word got;
        t_word want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = take_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 99) == 0)
                take_calm = !take_calm;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                seen = !empty;
                got  = '{o_out_byte, o_kind, o_line_index, o_is_last};
                @(posedge i_clk);
            end while (!seen);

            words_checked++;
            if (expected_words.size() == 0) begin
                $display("%0t: word with nothing expected, data=%0d kind=%0d line=%0d last=%0b",
                         $time, got.data, got.kind, got.line, got.last);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                compare_field("out_byte", LW'(want.data), LW'(got.data));
                compare_field("kind", LW'(want.kind), LW'(got.kind));
                compare_field("line_index", want.line, got.line);
                compare_field("is_last", LW'(want.last), LW'(got.last));
            end
        end
    end

    // reset, scripted lines, random lines, keyless line, drain
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < OPEN_ROWS; i++)
            feed_byte(script[i].din, script[i].typed, script[i].want);
        while (bytes_fed < OPEN_ROWS + RANDOM_ITEMS)
            send_random_line();
        for (int i = OPEN_ROWS; i < ROWS; i++)
            feed_byte(script[i].din, script[i].typed, script[i].want);
        push <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input words over %0d lines, %0d result words checked",
                 bytes_fed, line_no + 1, words_checked);
        $display("%0d escape warnings, %0d bytes with two words, halted on a keyless line",
                 warn_count, pair_count);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/jsfe_pkg.sv
rtl/core/jsfe_front.sv
rtl/core/jsfe_fifo.sv
rtl/core/jsfe_back.sv
rtl/core/jsonl_string_field_extractor.sv
tb/tb_top.sv
